[hdl/fct_pkg.sv]
// Package for the frustum cull tester: item kinds, sequencer states,
// the plane word layout and the control structs shared by the modules.
// No dependencies.
`default_nettype none

package fct_pkg;

    // Default configuration.
    localparam int DEF_NUM_PLANES = 6;
    localparam int DEF_FRAC_BITS  = 16;

    // Fixed field widths.
    localparam int COORD_W = 32;              // one Q16.16 input value
    localparam int EXT_W   = COORD_W + 1;     // centre +/- half-extent
    localparam int PROD_W  = COORD_W + EXT_W; // exact coefficient product

    // Item kinds.
    typedef enum logic [2:0] {
        KIND_LOAD   = 3'd0,
        KIND_POINT  = 3'd1,
        KIND_SPHERE = 3'd2,
        KIND_CBOX   = 3'd3,
        KIND_MMBOX  = 3'd4
    } t_kind;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_RESULT
    } t_state;

    // One stored plane: a*x + b*y + c*z + d.
    typedef struct packed {
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] c;
        logic signed [COORD_W-1:0] d;
    } t_plane;

    // Sequencer to datapath controls.
    typedef struct packed {
        logic start; // latch the test item and clear the cull flag
        logic re;    // a plane read is issued this cycle
        logic last;  // the issued read is the last plane
    } t_ctl;

    // Datapath to sequencer status.
    typedef struct packed {
        logic fin;    // the last plane has been evaluated
        logic culled; // some plane culls the shape
    } t_stat;

endpackage

`default_nettype wire

[hdl/fct_if.sv]
// Handshake interfaces of the frustum cull tester: the input item channel
// and the result channel. Depends on fct_pkg for field widths.
`default_nettype none

interface fct_in_if;
    import fct_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [2:0]                kind;
    logic [2:0]                plane_index;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bz;

    modport source (output valid, kind, plane_index, ax, ay, az, bx, by, bz,
                    input ready);
    modport sink   (input valid, kind, plane_index, ax, ay, az, bx, by, bz,
                    output ready);
endinterface

interface fct_out_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink   (input valid, visible, output ready);
endinterface

`default_nettype wire

[hdl/fct_plane_mem.sv]
// Plane store: a synchronous memory of plane words with registered read
// data, plus one valid bit per plane so that unwritten planes read as zero.
// Depends on fct_pkg.
`default_nettype none

module fct_plane_mem #(
    parameter int NUM_PLANES = fct_pkg::DEF_NUM_PLANES,
    parameter int AW         = 3
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_we,
    input  wire [AW-1:0]        i_waddr,
    input  fct_pkg::t_plane     i_wdata,
    input  wire                 i_re,
    input  wire [AW-1:0]        i_raddr,
    output fct_pkg::t_plane     o_rdata
);
    import fct_pkg::*;

    t_plane                r_mem [NUM_PLANES];
    logic [NUM_PLANES-1:0] r_valid;
    t_plane                r_rdata;
    logic                  r_rok;

    // Memory write and registered read. Loads and tests never overlap, so
    // no forwarding between the ports is needed.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // Written flags: reset returns every plane to all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rok   <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rok <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rok ? r_rdata : '0;

endmodule

`default_nettype wire

[hdl/fct_dist_pipe.sv]
// Distance datapath: holds the test item, picks the worst corner for each
// plane, forms the exact signed distance over three stages and folds the
// sign into a cull flag. Depends on fct_pkg.
`default_nettype none

module fct_dist_pipe #(
    parameter int FRAC_BITS = fct_pkg::DEF_FRAC_BITS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  fct_pkg::t_ctl                       i_ctl,
    input  wire [2:0]                           i_kind,
    input  wire signed [fct_pkg::COORD_W-1:0]   i_ax,
    input  wire signed [fct_pkg::COORD_W-1:0]   i_ay,
    input  wire signed [fct_pkg::COORD_W-1:0]   i_az,
    input  wire signed [fct_pkg::COORD_W-1:0]   i_bx,
    input  wire signed [fct_pkg::COORD_W-1:0]   i_by,
    input  wire signed [fct_pkg::COORD_W-1:0]   i_bz,
    input  fct_pkg::t_plane                     i_plane,
    output fct_pkg::t_stat                      o_stat
);
    import fct_pkg::*;

    localparam int SH_W  = COORD_W + FRAC_BITS;
    localparam int MAX_W = (PROD_W > SH_W) ? PROD_W : SH_W;
    localparam int SUM_W = MAX_W + 3;

    // Item registers: per axis the smaller and larger corner coordinate.
    logic signed [EXT_W-1:0]   r_mn [3];
    logic signed [EXT_W-1:0]   r_mx [3];
    logic signed [COORD_W-1:0] r_extra;
    logic signed [EXT_W-1:0]   n_mn [3];
    logic signed [EXT_W-1:0]   n_mx [3];
    logic signed [COORD_W-1:0] n_extra;

    logic signed [EXT_W-1:0]   w_a [3];
    logic signed [EXT_W-1:0]   w_b [3];
    logic signed [EXT_W-1:0]   w_lo [3];
    logic signed [EXT_W-1:0]   w_hi [3];

    // Pipeline stage registers.
    logic                      r_s2_v, r_s2_last, r_s3_v, r_s3_last, r_s1_v, r_s1_last;
    logic signed [PROD_W-1:0]  r_p [3];
    logic signed [PROD_W-1:0]  n_p [3];
    logic signed [SH_W-1:0]    r_dsh;
    logic signed [SH_W-1:0]    w_esh;
    logic signed [SUM_W-1:0]   r_sa, r_sb;
    logic signed [SUM_W-1:0]   w_total;
    logic signed [COORD_W-1:0] w_coef [3];
    logic signed [EXT_W-1:0]   w_sel [3];
    logic                      r_culled, r_fin;

    // Corner bounds of the incoming item. A point or sphere is a box of
    // zero size, so every shape takes the same per-plane path.
    always_comb begin
        w_a[0] = EXT_W'(i_ax);
        w_a[1] = EXT_W'(i_ay);
        w_a[2] = EXT_W'(i_az);
        w_b[0] = EXT_W'(i_bx);
        w_b[1] = EXT_W'(i_by);
        w_b[2] = EXT_W'(i_bz);
        n_extra = '0;
        for (int k = 0; k < 3; k++) begin
            w_lo[k] = w_a[k];
            w_hi[k] = w_a[k];
        end
        case (t_kind'(i_kind))
            KIND_SPHERE: n_extra = i_bx;
            KIND_CBOX: begin
                for (int k = 0; k < 3; k++) begin
                    w_lo[k] = w_a[k] - w_b[k];
                    w_hi[k] = w_a[k] + w_b[k];
                end
            end
            KIND_MMBOX: begin
                for (int k = 0; k < 3; k++) begin
                    w_hi[k] = w_b[k];
                end
            end
            default: ;
        endcase
        for (int k = 0; k < 3; k++) begin
            n_mn[k] = (w_hi[k] < w_lo[k]) ? w_hi[k] : w_lo[k];
            n_mx[k] = (w_hi[k] < w_lo[k]) ? w_lo[k] : w_hi[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_mn    <= n_mn;
            r_mx    <= n_mx;
            r_extra <= n_extra;
        end
    end

    // Worst corner for this plane: the largest coordinate where the
    // coefficient is non-negative, the smallest where it is negative.
    always_comb begin
        w_coef[0] = i_plane.a;
        w_coef[1] = i_plane.b;
        w_coef[2] = i_plane.c;
        for (int k = 0; k < 3; k++) begin
            w_sel[k] = w_coef[k][COORD_W-1] ? r_mn[k] : r_mx[k];
            n_p[k]   = PROD_W'(w_coef[k]) * PROD_W'(w_sel[k]);
        end
    end

    assign w_esh   = {r_extra, {FRAC_BITS{1'b0}}};
    assign w_total = r_sa + r_sb;

    // Payload stages: products, then two partial sums.
    always_ff @(posedge i_clk) begin
        r_p   <= n_p;
        r_dsh <= {i_plane.d, {FRAC_BITS{1'b0}}};
        r_sa  <= SUM_W'(r_p[0]) + SUM_W'(r_p[1]);
        r_sb  <= SUM_W'(r_p[2]) + SUM_W'(r_dsh) + SUM_W'(w_esh);
    end

    // Stage valid flags and the cull flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s2_last <= 1'b0;
            r_s3_v    <= 1'b0;
            r_s3_last <= 1'b0;
            r_fin     <= 1'b0;
            r_culled  <= 1'b0;
        end else begin
            r_s1_v    <= i_ctl.re;
            r_s1_last <= i_ctl.re & i_ctl.last;
            r_s2_v    <= r_s1_v;
            r_s2_last <= r_s1_last;
            r_s3_v    <= r_s2_v;
            r_s3_last <= r_s2_last;
            r_fin     <= r_s3_v & r_s3_last;
            if (i_ctl.start) begin
                r_culled <= 1'b0;
            end else if (r_s3_v && w_total[SUM_W-1]) begin
                r_culled <= 1'b1;
            end
        end
    end

    assign o_stat.fin    = r_fin;
    assign o_stat.culled = r_culled;

endmodule

`default_nettype wire

[hdl/fct_seq.sv]
// Sequencer: input handshake, plane loads, the plane read sweep for a
// test item and the result register. Depends on fct_pkg and fct_if.
`default_nettype none

module fct_seq #(
    parameter int NUM_PLANES = fct_pkg::DEF_NUM_PLANES,
    parameter int AW         = 3
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    fct_in_if.sink           i_in,
    fct_out_if.source        o_out,
    input  fct_pkg::t_stat   i_stat,
    output fct_pkg::t_ctl    o_ctl,
    output logic [AW-1:0]    o_raddr,
    output logic             o_we,
    output logic [AW-1:0]    o_waddr
);
    import fct_pkg::*;

    localparam int IDX_W = (AW > 3) ? AW : 3;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             r_visible, n_visible;
    logic             w_accept, w_out_free, w_last;
    logic [IDX_W-1:0] w_idx;

    assign w_accept   = i_in.valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_last     = (r_cnt == AW'(NUM_PLANES - 1));
    assign w_idx      = IDX_W'(i_in.plane_index);

    // State, sweep counter and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_visible <= n_visible;
    end

    // Next state, memory controls and result loading.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_visible   = r_visible;
        o_ctl       = '0;
        o_we        = 1'b0;
        o_waddr     = w_idx[AW-1:0];
        o_raddr     = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (t_kind'(i_in.kind)) inside
                        KIND_LOAD: begin
                            o_we = ({2'b00, w_idx} < (IDX_W + 2)'(NUM_PLANES));
                        end
                        KIND_POINT, KIND_SPHERE, KIND_CBOX, KIND_MMBOX: begin
                            o_ctl.start = 1'b1;
                            n_cnt       = '0;
                            n_state     = ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                o_ctl.re   = 1'b1;
                o_ctl.last = w_last;
                if (w_last) begin
                    n_state = ST_WAIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_WAIT: begin
                if (i_stat.fin) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_visible   = !i_stat.culled;
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_visible   = !i_stat.culled;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign i_in.ready    = (r_state == ST_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.visible = r_visible;

endmodule

`default_nettype wire

[hdl/frustum_cull_tester.sv]
// Top level of the frustum cull tester: sequencer, plane memory and
// distance datapath. Depends on fct_pkg, fct_if and the fct_* modules.
//
// Six-plane view frustum culling in signed fixed point. A load item (kind 0)
// writes plane a,b,c,d from ax,ay,az,bx into the plane memory and gives no
// result; an index at or above NUM_PLANES is dropped, and kinds 5 to 7 are
// dropped as well. A test item (point, sphere, centre box, min-max box)
// sweeps the plane memory one plane per cycle; for each plane the worst
// corner of the shape is chosen from the coefficient signs and its distance
// is formed exactly over three pipeline stages. The result waits for the
// sweep of the read port and the drain of the distance pipeline, and input
// ready is low from acceptance until the result is loaded into the output
// register. A result waiting in the output register does not stop a new
// item from being accepted. All planes read as zero after reset.
`default_nettype none

module frustum_cull_tester #(
    parameter int NUM_PLANES = fct_pkg::DEF_NUM_PLANES,
    parameter int FRAC_BITS  = fct_pkg::DEF_FRAC_BITS
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    fct_in_if.sink       i_in_item,
    fct_out_if.source    o_res
);
    import fct_pkg::*;

    localparam int AW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    t_ctl          w_ctl;
    t_stat         w_stat;
    t_plane        w_rdata;
    t_plane        w_wdata;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_waddr;
    logic          w_we;

    // Plane word taken from a load item.
    assign w_wdata.a = i_in_item.ax;
    assign w_wdata.b = i_in_item.ay;
    assign w_wdata.c = i_in_item.az;
    assign w_wdata.d = i_in_item.bx;

    fct_seq #(
        .NUM_PLANES (NUM_PLANES),
        .AW         (AW)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in_item),
        .o_out   (o_res),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl),
        .o_raddr (w_raddr),
        .o_we    (w_we),
        .o_waddr (w_waddr)
    );

    fct_plane_mem #(
        .NUM_PLANES (NUM_PLANES),
        .AW         (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_ctl.re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fct_dist_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_kind  (i_in_item.kind),
        .i_ax    (i_in_item.ax),
        .i_ay    (i_in_item.ay),
        .i_az    (i_in_item.az),
        .i_bx    (i_in_item.bx),
        .i_by    (i_in_item.by),
        .i_bz    (i_in_item.bz),
        .i_plane (w_rdata),
        .o_stat  (w_stat)
    );

endmodule

`default_nettype wire

[verif/tb_frustum_cull_tester.sv]
`timescale 1ns / 100ps
// Self-checking testbench for frustum_cull_tester: queued item driver, result monitor
// and a cycle-free visibility predictor. Depends on fct_pkg, fct_if and the RTL.

module tb_frustum_cull_tester;
    import fct_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 10;
    localparam int FLUSH_CYCLES = 40;
    localparam int CHUNK_ITEMS  = 650;
    localparam int TIMEOUT_NS   = 10_000_000;
    localparam int ACC_W        = 96;
    localparam int Q_ONE        = 1 << DEF_FRAC_BITS;

    localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

    // Kind codes that the block drops without a result.
    localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
    localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;

    typedef struct {
        logic [2:0]                kind;
        logic [2:0]                plane_index;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bz;
    } t_cull_item;

    logic i_clk;
    logic i_rst_n;

    fct_in_if  in_if ();
    fct_out_if res_if ();

    frustum_cull_tester uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_item (in_if),
        .o_res     (res_if)
    );

    t_cull_item pending_items[$];
    bit         visible_expected[$];
    t_plane     plane_mem [DEF_NUM_PLANES];
    t_cull_item driven_item;
    bit         in_taken;
    int         idle_left;
    int         stall_left;
    bit         src_calm;
    bit         snk_calm;
    int         mismatch_count;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Visibility predictor
    // ------------------------------------------------------------------

    // Signed distance of a point to plane p plus an offset, scaled by 2^(2*FRAC).
    function automatic logic signed [ACC_W-1:0] plane_dist(
        int p,
        logic signed [ACC_W-1:0] x,
        logic signed [ACC_W-1:0] y,
        logic signed [ACC_W-1:0] z,
        logic signed [ACC_W-1:0] extra
    );
        logic signed [ACC_W-1:0] pa, pb, pc, pd;
        pa = $signed(plane_mem[p].a);
        pb = $signed(plane_mem[p].b);
        pc = $signed(plane_mem[p].c);
        pd = $signed(plane_mem[p].d);
        return pa * x + pb * y + pc * z + ((pd + extra) <<< DEF_FRAC_BITS);
    endfunction

    // A box is culled when some single plane has all eight corners behind it.
    function automatic bit box_seen(
        logic signed [ACC_W-1:0] lx, logic signed [ACC_W-1:0] ly,
        logic signed [ACC_W-1:0] lz, logic signed [ACC_W-1:0] hx,
        logic signed [ACC_W-1:0] hy, logic signed [ACC_W-1:0] hz
    );
        bit all_behind;
        bit seen;
        seen = 1'b1;
        for (int p = 0; p < DEF_NUM_PLANES; p++) begin
            all_behind = 1'b1;
            for (int c = 0; c < 8; c++) begin
                if (plane_dist(p, (c & 1) ? hx : lx, (c & 2) ? hy : ly,
                               (c & 4) ? hz : lz, '0) >= 0)
                    all_behind = 1'b0;
            end
            if (all_behind)
                seen = 1'b0;
        end
        return seen;
    endfunction

    // Applies one accepted item: updates the planes or queues the expected flag.
    task automatic cull_predict(t_cull_item it);
        logic signed [ACC_W-1:0] cx, cy, cz, ex, ey, ez;
        bit vis;
        bit has_res;
        cx = it.ax;
        cy = it.ay;
        cz = it.az;
        ex = it.bx;
        ey = it.by;
        ez = it.bz;
        vis = 1'b1;
        has_res = 1'b0;
        case (it.kind)
            KIND_LOAD: begin
                if (it.plane_index < DEF_NUM_PLANES)
                    plane_mem[it.plane_index] = '{a: it.ax, b: it.ay, c: it.az, d: it.bx};
            end
            KIND_POINT: begin
                has_res = 1'b1;
                for (int p = 0; p < DEF_NUM_PLANES; p++)
                    if (plane_dist(p, cx, cy, cz, '0) < 0) vis = 1'b0;
            end
            KIND_SPHERE: begin
                has_res = 1'b1;
                for (int p = 0; p < DEF_NUM_PLANES; p++)
                    if (plane_dist(p, cx, cy, cz, ex) < 0) vis = 1'b0;
            end
            KIND_CBOX: begin
                has_res = 1'b1;
                vis = box_seen(cx - ex, cy - ey, cz - ez, cx + ex, cy + ey, cz + ez);
            end
            KIND_MMBOX: begin
                has_res = 1'b1;
                vis = box_seen(cx, cy, cz, ex, ey, ez);
            end
            default: ;
        endcase
        if (has_res)
            visible_expected.push_back(vis);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_item(
        logic [2:0] kind, logic [2:0] idx,
        logic signed [COORD_W-1:0] ax, logic signed [COORD_W-1:0] ay,
        logic signed [COORD_W-1:0] az, logic signed [COORD_W-1:0] bx,
        logic signed [COORD_W-1:0] by, logic signed [COORD_W-1:0] bz
    );
        t_cull_item it;
        it.kind = kind;
        it.plane_index = idx;
        it.ax = ax;
        it.ay = ay;
        it.az = az;
        it.bx = bx;
        it.by = by;
        it.bz = bz;
        pending_items.push_back(it);
    endtask

    // Uniform value in [-lim, lim] raw units.
    function automatic int small_frac(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // Full-range word, an extreme value, or a moderate Q16.16 number.
    function automatic logic signed [COORD_W-1:0] rand_q();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return small_frac(100 * Q_ONE);
        if (r < 85)
            return $urandom;
        case ($urandom_range(0, 6))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return 0;
            3: return -1;
            4: return 1;
            5: return Q_ONE;
            default: return -Q_ONE;
        endcase
    endfunction

    // Coordinates mostly near the frustums built below.
    function automatic logic signed [COORD_W-1:0] coord();
        if ($urandom_range(0, 99) < 80)
            return small_frac(64 * Q_ONE);
        return rand_q();
    endfunction

    // Radius or half-extent: mostly a sane positive size.
    function automatic logic signed [COORD_W-1:0] extent(int units);
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, units * Q_ONE);
        return rand_q();
    endfunction

    // Random plane index, including the ones past the last plane.
    function automatic logic [2:0] rand_idx();
        return 3'($urandom_range(0, 7));
    endfunction

    // Six inward-facing planes of a slightly skewed axis-aligned box.
    task automatic queue_frustum();
        int half_size;
        logic signed [COORD_W-1:0] n [3];
        half_size = $urandom_range(2, 48);
        for (int i = 0; i < DEF_NUM_PLANES; i++) begin
            for (int k = 0; k < 3; k++)
                n[k] = small_frac(Q_ONE / 20);
            n[i / 2] = (i % 2 == 0) ? n[i / 2] + Q_ONE : n[i / 2] - Q_ONE;
            queue_item(KIND_LOAD, 3'(i), n[0], n[1], n[2],
                       half_size * Q_ONE + small_frac(2 * Q_ONE), rand_q(), rand_q());
        end
    endtask

    task automatic queue_random_test();
        logic [2:0] kind;
        logic signed [COORD_W-1:0] ax, ay, az;
        kind = 3'($urandom_range(KIND_POINT, KIND_MMBOX));
        ax = coord();
        ay = coord();
        az = coord();
        case (kind)
            KIND_POINT:
                queue_item(kind, rand_idx(), ax, ay, az, rand_q(), rand_q(), rand_q());
            KIND_SPHERE:
                queue_item(kind, rand_idx(), ax, ay, az, extent(24), rand_q(), rand_q());
            KIND_CBOX:
                queue_item(kind, rand_idx(), ax, ay, az, extent(16), extent(16),
                           extent(16));
            default:
                queue_item(kind, rand_idx(), ax, ay, az, ax + extent(20),
                           ay + extent(20), az + extent(20));
        endcase
    endtask

    // Random mix of tests, frustum reloads, stray loads and dropped kinds.
    task automatic queue_random_chunk(int count);
        int n;
        int r;
        n = 0;
        while (n < count) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                queue_frustum();
                n += DEF_NUM_PLANES;
            end else if (r < 8) begin
                if ($urandom_range(0, 1) == 0)
                    queue_item(KIND_LOAD, rand_idx(), small_frac(Q_ONE),
                               small_frac(Q_ONE), small_frac(Q_ONE), small_frac(40 * Q_ONE),
                               rand_q(), rand_q());
                else
                    queue_item(KIND_LOAD, rand_idx(), rand_q(), rand_q(), rand_q(),
                               rand_q(), rand_q(), rand_q());
                n++;
            end else if (r < 10) begin
                queue_item(3'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST)),
                           rand_idx(), rand_q(), rand_q(), rand_q(), rand_q(),
                           rand_q(), rand_q());
            end else begin
                queue_random_test();
                n++;
            end
        end
    endtask

    // Gap length: mostly none or short, now and then long.
    function automatic int idle_cycles(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 15);
        return $urandom_range(16, 40);
    endfunction

    // Holds the test sequence until every queued item is taken and every result seen.
    task automatic drain_results();
        while (pending_items.size() != 0 || in_if.valid || visible_expected.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Item driver, changes inputs on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_if.valid && !in_taken) begin
            // Hold the current item until it is taken.
        end else if (idle_left > 0) begin
            in_if.valid <= 1'b0;
            idle_left--;
        end else if (pending_items.size() != 0) begin
            if ($urandom_range(0, 99) == 0)
                src_calm = !src_calm;
            driven_item = pending_items.pop_front();
            in_if.kind <= driven_item.kind;
            in_if.plane_index <= driven_item.plane_index;
            in_if.ax <= driven_item.ax;
            in_if.ay <= driven_item.ay;
            in_if.az <= driven_item.az;
            in_if.bx <= driven_item.bx;
            in_if.by <= driven_item.by;
            in_if.bz <= driven_item.bz;
            in_if.valid <= 1'b1;
            idle_left = idle_cycles(src_calm);
        end else begin
            in_if.valid <= 1'b0;
        end
    end

    // Result back-pressure.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0)
                snk_calm = !snk_calm;
            if (stall_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = idle_cycles(snk_calm);
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each taken item, checks each taken result
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit want;
        if (!i_rst_n) begin
            in_taken = 1'b0;
            foreach (plane_mem[i])
                plane_mem[i] = '0;
        end else begin
            in_taken = in_if.valid && in_if.ready;
            if (in_taken)
                cull_predict(driven_item);
            if (res_if.valid && res_if.ready) begin
                if (visible_expected.size() == 0) begin
                    $error("visible: expected no result, actual %0b", res_if.visible);
                    mismatch_count++;
                end else begin
                    want = visible_expected.pop_front();
                    if (res_if.visible !== want) begin
                        $error("visible: expected %0b, actual %0b", want, res_if.visible);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.kind = KIND_LOAD;
        in_if.plane_index = '0;
        in_if.ax = '0;
        in_if.ay = '0;
        in_if.az = '0;
        in_if.bx = '0;
        in_if.by = '0;
        in_if.bz = '0;
        res_if.ready = 1'b0;
        in_taken = 1'b0;
        idle_left = 0;
        stall_left = 0;
        src_calm = 1'b0;
        snk_calm = 1'b0;
        mismatch_count = 0;

        // Planes zero after reset: only the negative-radius sphere is culled.
        queue_item(KIND_POINT, 3'd7, Q_MIN, Q_MAX, 0, Q_MAX, Q_MIN, -1);
        queue_item(KIND_SPHERE, 3'd0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0, 0);
        queue_item(KIND_CBOX, 3'd5, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        queue_item(KIND_MMBOX, 3'd2, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);

        // Dropped kinds.
        for (int k = KIND_RSVD_FIRST; k <= KIND_RSVD_LAST; k++)
            queue_item(3'(k), 3'd3, rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());

        // Loads past the last plane must not take effect.
        queue_item(KIND_LOAD, 3'd6, 0, 0, 0, -Q_ONE, 0, 0);
        queue_item(KIND_LOAD, 3'd7, 0, 0, 0, -Q_ONE, 0, 0);
        queue_item(KIND_POINT, 3'd0, 0, 0, 0, 0, 0, 0);

        // Plane 0 is x >= 0; probe the boundary for each shape.
        queue_item(KIND_LOAD, 3'd0, Q_ONE, 0, 0, 0, 0, 0);
        queue_item(KIND_POINT, 3'd0, -1, 0, 0, 0, 0, 0);
        queue_item(KIND_POINT, 3'd0, 0, 0, 0, 0, 0, 0);
        queue_item(KIND_SPHERE, 3'd0, -2 * Q_ONE, 0, 0, 2 * Q_ONE, 0, 0);
        queue_item(KIND_SPHERE, 3'd0, -2 * Q_ONE, 0, 0, 2 * Q_ONE - 1, 0, 0);
        queue_item(KIND_SPHERE, 3'd0, 0, 0, 0, -1, 0, 0);
        queue_item(KIND_CBOX, 3'd0, -3 * Q_ONE, 0, 0, 3 * Q_ONE, Q_ONE, Q_ONE);
        queue_item(KIND_CBOX, 3'd0, -3 * Q_ONE, 0, 0, 2 * Q_ONE, Q_ONE, Q_ONE);
        // Negative half-extent just swaps the corners.
        queue_item(KIND_CBOX, 3'd0, -3 * Q_ONE, 0, 0, -3 * Q_ONE, -Q_ONE, -Q_ONE);
        queue_item(KIND_MMBOX, 3'd0, -5 * Q_ONE, 0, 0, -Q_ONE, Q_ONE, Q_ONE);
        // Min above max just swaps the corners.
        queue_item(KIND_MMBOX, 3'd0, Q_ONE, 0, 0, -5 * Q_ONE, -Q_ONE, -Q_ONE);

        // Extreme coefficients and widened box corners.
        queue_item(KIND_LOAD, 3'd5, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 0, 0);
        queue_item(KIND_POINT, 3'd0, Q_MAX, Q_MIN, Q_MAX, 0, 0, 0);
        queue_item(KIND_CBOX, 3'd0, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        queue_item(KIND_SPHERE, 3'd0, Q_MIN, Q_MIN, Q_MAX, Q_MAX, 0, 0);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items first, then random chunks with a full drain between them.
        drain_results();
        for (int c = 0; c < 3; c++) begin
            queue_random_chunk(CHUNK_ITEMS);
            drain_results();
        end

        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/fct_pkg.sv
hdl/fct_if.sv
hdl/fct_plane_mem.sv
hdl/fct_dist_pipe.sv
hdl/fct_seq.sv
hdl/frustum_cull_tester.sv
verif/tb_frustum_cull_tester.sv
